### src/lcg63_with_jump_ahead_assert.svh
// Assertion macros for the 63-bit LCG block.
// Used by src/lcg63_with_jump_ahead.sv; depends on a clock named i_clk and reset i_rst_n.
`ifndef LCG63_WITH_JUMP_AHEAD_ASSERT_SVH
`define LCG63_WITH_JUMP_AHEAD_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LCG63_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LCG63_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/lcg63_pkg.sv
// Shared constants and types for the 63-bit LCG with jump-ahead.
// No dependencies; used by src/lcg63_with_jump_ahead.sv.
package lcg63_pkg;

    localparam int SEED_W = 63;
    localparam int HALF_W = 32;
    localparam int HIGH_W = SEED_W - HALF_W;

    typedef logic [SEED_W-1:0] t_seed;
    typedef logic [1:0]        t_opcode;

    localparam t_seed LCG_MUL = 63'd2806196910506780709;
    localparam t_seed LCG_INC = 63'd1;

    // Opcodes of an input item
    localparam t_opcode OP_LOAD = 2'd0;
    localparam t_opcode OP_DRAW = 2'd1;
    localparam t_opcode OP_JUMP = 2'd2;

    // Index of the last skip-count bit
    localparam logic [5:0] LAST_BIT = 6'd62;

endpackage

### src/lcg63_with_jump_ahead.sv
// 63-bit LCG (seed' = A*seed + 1 mod 2^63) with jump-ahead by repeated squaring.
// Depends on src/lcg63_pkg.sv and src/lcg63_with_jump_ahead_assert.svh.
//
// Load or unused opcode: result registered directly; draw: three 32x32 partial products.
// Jump: MA, IA (set bits only), IS and MS per skip-count bit, then FIN, all on the one
// shared 32x32 multiplier. A new item is taken on the cycle its result transfers.
// Reset (synchronous, active low) clears the seed to zero and returns the sequencer to idle.
module lcg63_with_jump_ahead (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [lcg63_pkg::SEED_W-1:0]  i_seed_value,
    input  logic [lcg63_pkg::SEED_W-1:0]  i_skip_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lcg63_pkg::SEED_W-1:0]  o_seed_out
);

`include "lcg63_with_jump_ahead_assert.svh"

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Multiply-add jobs of the shared unit
    localparam logic [2:0] SUB_DRAW = 3'd0;
    localparam logic [2:0] SUB_MA   = 3'd1;
    localparam logic [2:0] SUB_IA   = 3'd2;
    localparam logic [2:0] SUB_IS   = 3'd3;
    localparam logic [2:0] SUB_MS   = 3'd4;
    localparam logic [2:0] SUB_FIN  = 3'd5;

    // Partial-product phases
    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_CROSS0 = 2'd1;
    localparam logic [1:0] PH_CROSS1 = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [2:0]       r_sub, n_sub;
    logic [1:0]       r_phase, n_phase;
    logic [5:0]       r_bit, n_bit;
    lcg63_pkg::t_seed r_seed, n_seed;
    lcg63_pkg::t_seed r_acc, n_acc;
    lcg63_pkg::t_seed r_ma, n_ma;
    lcg63_pkg::t_seed r_ia, n_ia;
    lcg63_pkg::t_seed r_ms, n_ms;
    lcg63_pkg::t_seed r_is, n_is;
    lcg63_pkg::t_seed r_x, n_x;
    lcg63_pkg::t_seed r_cnt, n_cnt;

    logic             in_xfer;
    logic             out_xfer;
    lcg63_pkg::t_seed op_a, op_b, op_add;
    logic [lcg63_pkg::HALF_W-1:0]   mul_x, mul_y;
    logic [2*lcg63_pkg::HALF_W-1:0] prod;
    lcg63_pkg::t_seed acc_next;

    // Handshake
    assign o_out_valid = (r_state == ST_DONE);
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state == ST_MUL) || ((r_state == ST_DONE) && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_seed_out  = r_seed;

    // Select operands of the shared multiply-add
    always_comb begin
        op_a   = r_seed;
        op_b   = lcg63_pkg::LCG_MUL;
        op_add = '0;
        unique case (r_sub)
            SUB_DRAW: begin
                op_a   = r_seed;
                op_b   = lcg63_pkg::LCG_MUL;
                op_add = lcg63_pkg::LCG_INC;
            end
            SUB_MA: begin
                op_a = r_ma;
                op_b = r_ms;
            end
            SUB_IA: begin
                op_a   = r_ia;
                op_b   = r_ms;
                op_add = r_is;
            end
            SUB_IS: begin
                op_a = r_is;
                op_b = r_ms + lcg63_pkg::t_seed'(1);
            end
            SUB_MS: begin
                op_a = r_ms;
                op_b = r_ms;
            end
            SUB_FIN: begin
                op_a   = r_ma;
                op_b   = r_x;
                op_add = r_ia;
            end
            default: begin
                op_a = r_seed;
            end
        endcase
    end

    // One 32x32 partial product per phase; the high*high term drops out mod 2^63
    always_comb begin
        unique case (r_phase)
            PH_LOW: begin
                mul_x = op_a[lcg63_pkg::HALF_W-1:0];
                mul_y = op_b[lcg63_pkg::HALF_W-1:0];
            end
            PH_CROSS0: begin
                mul_x = op_a[lcg63_pkg::HALF_W-1:0];
                mul_y = {1'b0, op_b[lcg63_pkg::SEED_W-1:lcg63_pkg::HALF_W]};
            end
            default: begin
                mul_x = {1'b0, op_a[lcg63_pkg::SEED_W-1:lcg63_pkg::HALF_W]};
                mul_y = op_b[lcg63_pkg::HALF_W-1:0];
            end
        endcase
        prod = mul_x * mul_y;
        if (r_phase == PH_LOW) begin
            acc_next = prod[lcg63_pkg::SEED_W-1:0] + op_add;
        end else begin
            acc_next = r_acc + {prod[lcg63_pkg::HIGH_W-1:0], {lcg63_pkg::HALF_W{1'b0}}};
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_seed  = r_seed;
        n_acc   = r_acc;
        n_ma    = r_ma;
        n_ia    = r_ia;
        n_ms    = r_ms;
        n_is    = r_is;
        n_x     = r_x;
        n_cnt   = r_cnt;

        // Drop the finished result
        if (out_xfer) begin
            n_state = ST_IDLE;
        end

        if (r_state == ST_MUL) begin
            n_acc = acc_next;
            if (r_phase != PH_CROSS1) begin
                n_phase = r_phase + 2'd1;
            end else begin
                n_phase = PH_LOW;
                unique case (r_sub)
                    SUB_DRAW: begin
                        n_seed  = acc_next;
                        n_state = ST_DONE;
                    end
                    SUB_MA: begin
                        n_ma  = acc_next;
                        n_sub = SUB_IA;
                    end
                    SUB_IA: begin
                        n_ia  = acc_next;
                        n_sub = SUB_IS;
                    end
                    SUB_IS: begin
                        n_is  = acc_next;
                        n_sub = SUB_MS;
                    end
                    SUB_MS: begin
                        n_ms = acc_next;
                        if (r_bit == lcg63_pkg::LAST_BIT) begin
                            n_sub = SUB_FIN;
                        end else begin
                            n_bit = r_bit + 6'd1;
                            n_cnt = r_cnt >> 1;
                            n_sub = r_cnt[1] ? SUB_MA : SUB_IS;
                        end
                    end
                    SUB_FIN: begin
                        n_seed  = acc_next;
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
        end

        // Start a new item on input transfer
        if (in_xfer) begin
            n_phase = PH_LOW;
            priority if (i_opcode == lcg63_pkg::OP_LOAD) begin
                n_seed  = i_seed_value;
                n_state = ST_DONE;
            end else if (i_opcode == lcg63_pkg::OP_DRAW) begin
                n_sub   = SUB_DRAW;
                n_state = ST_MUL;
            end else if (i_opcode == lcg63_pkg::OP_JUMP) begin
                n_ma    = lcg63_pkg::t_seed'(1);
                n_ia    = '0;
                n_ms    = lcg63_pkg::LCG_MUL;
                n_is    = lcg63_pkg::LCG_INC;
                n_x     = i_seed_value;
                n_cnt   = i_skip_count;
                n_bit   = '0;
                n_sub   = i_skip_count[0] ? SUB_MA : SUB_IS;
                n_state = ST_MUL;
            end else begin
                n_state = ST_DONE;
            end
        end
    end

    // Control state and seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= '0;
            r_sub   <= SUB_DRAW;
            r_phase <= PH_LOW;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
            r_sub   <= n_sub;
            r_phase <= n_phase;
            r_bit   <= n_bit;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_ma  <= n_ma;
        r_ia  <= n_ia;
        r_ms  <= n_ms;
        r_is  <= n_is;
        r_x   <= n_x;
        r_cnt <= n_cnt;
    end

    `LCG63_ASSERT_NOW(a_phase_range, r_state == ST_MUL, r_phase != 2'd3, "bad multiply phase")
    `LCG63_ASSERT_NOW(a_bit_range, r_state == ST_MUL, r_bit <= lcg63_pkg::LAST_BIT, "skip bit overrun")
    `LCG63_ASSERT_NEXT(a_draw_start, in_xfer && i_opcode == lcg63_pkg::OP_DRAW, r_state == ST_MUL && r_sub == SUB_DRAW && r_phase == PH_LOW, "draw did not start")
    `LCG63_ASSERT_NEXT(a_load_echo, in_xfer && i_opcode == lcg63_pkg::OP_LOAD, o_out_valid && o_seed_out == $past(i_seed_value), "load not echoed")

endmodule
